>>> rtl/rsa_key_pair_derivation_defines.svh
// Assertion macros shared by the key derivation RTL.
// Taken in by the files that check their own sequencing; depends on nothing.
`ifndef RSA_KEY_PAIR_DERIVATION_DEFINES_SVH
`define RSA_KEY_PAIR_DERIVATION_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RKD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rkd_pkg.sv
// Shared constants for the key derivation block.
// Used by the top level and its arithmetic units; depends on nothing.
package rkd_pkg;

  // Default width of each prime factor.
  localparam int unsigned RKD_PRIME_BITS = 16;
  // Width of the public exponent field.
  localparam int unsigned RKD_EXP_BITS   = 32;
  // Width of the reported modulus and private exponent.
  localparam int unsigned RKD_OUT_BITS   = 32;

endpackage

>>> rtl/rsa_key_pair_derivation.sv
// Top level of the RSA key pair derivation block: sequencer and operand registers.
// Depends on rkd_pkg, rkd_div, rkd_mulmod and rsa_key_pair_derivation_defines.svh.
//
// One item carries two primes p and q and a public exponent e; the block returns
// the modulus p*q and the private exponent d, the inverse of e modulo
// phi = (p-1)(q-1), with inverse_found set when that inverse exists. A factor of
// 0 or 1 counts as a term of 0, and a totient below two, or an exponent that
// shares a factor with phi, gives inverse_found low and a zero exponent. Both
// outputs are the low 32 bits of values formed at full width. The block works on
// one item at a time and holds in_stall_o high from acceptance until the result
// is written to the output register; a finished result may wait there while the
// next item is already accepted. An item passes through setup and the reduction
// of e modulo phi, then through rounds of the extended Euclidean algorithm, each
// a division and a modular multiplication, and last through the final loop test
// and the hand-off to the output register; the number of rounds is at most about
// 1.44 * 2*PRIME_BITS. The hand-off waits further while the output register
// holds an earlier result that is stalled. The bit-serial divider does most of
// that work; the serial modular multiplier does the rest.
module rsa_key_pair_derivation #(
  parameter int unsigned PRIME_BITS = rkd_pkg::RKD_PRIME_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [PRIME_BITS-1:0]           prime_p_i,
  input  logic [PRIME_BITS-1:0]           prime_q_i,
  input  logic [rkd_pkg::RKD_EXP_BITS-1:0] public_exponent_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rkd_pkg::RKD_OUT_BITS-1:0] modulus_o,
  output logic [rkd_pkg::RKD_OUT_BITS-1:0] private_exponent_o,
  output logic                            inverse_found_o
);
  import rkd_pkg::*;

`include "rsa_key_pair_derivation_defines.svh"

  // Width of phi, the remainders and the Bezout coefficients.
  localparam int unsigned W  = 2 * PRIME_BITS;
  // Width of a dividend: wide enough for both e and any remainder.
  localparam int unsigned DW = (W > RKD_EXP_BITS) ? W : RKD_EXP_BITS;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;  // waiting for an item
  localparam logic [3:0] S_MODN = 4'd1;  // multiplier forms p*q
  localparam logic [3:0] S_PHI  = 4'd2;  // multiplier forms (p-1)(q-1)
  localparam logic [3:0] S_CHK  = 4'd3;  // test phi, start e mod phi
  localparam logic [3:0] S_REDE = 4'd4;  // wait for e mod phi
  localparam logic [3:0] S_TEST = 4'd5;  // Euclid loop test, start a division
  localparam logic [3:0] S_QUO  = 4'd6;  // wait for quotient and remainder
  localparam logic [3:0] S_MMUL = 4'd7;  // wait for quo*s1 mod phi
  localparam logic [3:0] S_FIN  = 4'd8;  // hand the result to the output register

  logic [3:0] state_q, state_d;

  logic [PRIME_BITS-1:0]   p_q, p_d;
  logic [PRIME_BITS-1:0]   q_q, q_d;
  logic [RKD_EXP_BITS-1:0] e_q, e_d;
  logic [W-1:0]            mod_q, mod_d;
  logic [W-1:0]            phi_q, phi_d;
  logic [W-1:0]            r0_q, r0_d;
  logic [W-1:0]            r1_q, r1_d;
  logic [W-1:0]            r2_q, r2_d;
  logic [W-1:0]            s0_q, s0_d;
  logic [W-1:0]            s1_q, s1_d;
  logic [W-1:0]            d_q, d_d;
  logic                    found_q, found_d;

  logic                    out_valid_q, out_valid_d;
  logic [RKD_OUT_BITS-1:0] out_mod_q, out_mod_d;
  logic [RKD_OUT_BITS-1:0] out_exp_q, out_exp_d;
  logic                    out_found_q, out_found_d;

  logic                  in_accept;
  logic                  out_free;
  logic [PRIME_BITS-1:0] pm1, qm1;
  logic [PRIME_BITS-1:0] mul_a, mul_b;
  logic [W-1:0]          mul_y;

  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [W-1:0]  div_divisor;
  logic          div_done;
  logic [W-1:0]  div_quo;
  logic [W-1:0]  div_rem;

  logic          mm_start;
  logic          mm_done;
  logic [W-1:0]  mm_prod;
  logic [W-1:0]  s2;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;

  // A factor below one contributes a zero term, as the totient formula expects.
  assign pm1 = (p_q != '0) ? (p_q - PRIME_BITS'(1)) : '0;
  assign qm1 = (q_q != '0) ? (q_q - PRIME_BITS'(1)) : '0;

  // One multiplier, used for the modulus and then for the totient.
  assign mul_a = (state_q == S_MODN) ? p_q : pm1;
  assign mul_b = (state_q == S_MODN) ? q_q : qm1;
  assign mul_y = W'(mul_a) * W'(mul_b);

  // The divider first reduces e modulo phi, then serves every Euclid round.
  assign div_start    = (state_q == S_CHK && phi_q >= W'(2)) ||
                        (state_q == S_TEST && r1_q != '0);
  assign div_dividend = (state_q == S_CHK) ? DW'(e_q) : DW'(r0_q);
  assign div_divisor  = (state_q == S_CHK) ? phi_q : r1_q;

  assign mm_start = (state_q == S_QUO) && div_done;

  // New coefficient s0 - quo*s1, kept in the range 0..phi-1.
  assign s2 = (s0_q >= mm_prod) ? (s0_q - mm_prod) : (s0_q + (phi_q - mm_prod));

  rkd_div #(
    .W (W),
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  rkd_mulmod #(
    .W(W)
  ) u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mm_start),
    .a_i      (s1_q),
    .b_i      (div_quo),
    .m_i      (phi_q),
    .done_o   (mm_done),
    .product_o(mm_prod)
  );

  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    q_d         = q_q;
    e_d         = e_q;
    mod_d       = mod_q;
    phi_d       = phi_q;
    r0_d        = r0_q;
    r1_d        = r1_q;
    r2_d        = r2_q;
    s0_d        = s0_q;
    s1_d        = s1_q;
    d_d         = d_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_mod_d   = out_mod_q;
    out_exp_d   = out_exp_q;
    out_found_d = out_found_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          p_d     = prime_p_i;
          q_d     = prime_q_i;
          e_d     = public_exponent_i;
          state_d = S_MODN;
        end
      end
      S_MODN: begin
        mod_d   = mul_y;
        state_d = S_PHI;
      end
      S_PHI: begin
        phi_d   = mul_y;
        state_d = S_CHK;
      end
      S_CHK: begin
        // With phi below two the range of candidates is empty.
        if (phi_q < W'(2)) begin
          d_d     = '0;
          found_d = 1'b0;
          state_d = S_FIN;
        end else begin
          state_d = S_REDE;
        end
      end
      S_REDE: begin
        if (div_done) begin
          r0_d    = phi_q;
          r1_d    = div_rem;
          s0_d    = '0;
          s1_d    = W'(1);
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        if (r1_q == '0) begin
          // The last nonzero remainder is the gcd; only a gcd of one has an inverse.
          if (r0_q == W'(1) && s0_q != '0) begin
            d_d     = s0_q;
            found_d = 1'b1;
          end else begin
            d_d     = '0;
            found_d = 1'b0;
          end
          state_d = S_FIN;
        end else begin
          state_d = S_QUO;
        end
      end
      S_QUO: begin
        if (div_done) begin
          r2_d    = div_rem;
          state_d = S_MMUL;
        end
      end
      S_MMUL: begin
        if (mm_done) begin
          r0_d    = r1_q;
          r1_d    = r2_q;
          s0_d    = s1_q;
          s1_d    = s2;
          state_d = S_TEST;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_mod_d   = RKD_OUT_BITS'(mod_q);
          out_exp_d   = RKD_OUT_BITS'(d_q);
          out_found_d = found_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    q_q         <= q_d;
    e_q         <= e_d;
    mod_q       <= mod_d;
    phi_q       <= phi_d;
    r0_q        <= r0_d;
    r1_q        <= r1_d;
    r2_q        <= r2_d;
    s0_q        <= s0_d;
    s1_q        <= s1_d;
    d_q         <= d_d;
    found_q     <= found_d;
    out_mod_q   <= out_mod_d;
    out_exp_q   <= out_exp_d;
    out_found_q <= out_found_d;
  end

  assign out_valid_o        = out_valid_q;
  assign modulus_o          = out_mod_q;
  assign private_exponent_o = out_exp_q;
  assign inverse_found_o    = out_found_q;

  // The current remainder r1 and both coefficients stay reduced below phi throughout the loop.
  `RKD_ASSERT_NOW(a_loop_reduced, clk_i, rst_ni, (state_q == S_TEST), ((r1_q < phi_q) && (s0_q < phi_q) && (s1_q < phi_q)), "Euclid operands not reduced modulo phi")
  // A result without an inverse always reports a zero exponent.
  `RKD_ASSERT_NOW(a_zero_when_none, clk_i, rst_ni, (out_valid_o && !inverse_found_o), (private_exponent_o == '0), "exponent nonzero without an inverse")
  // The output register fills only from the final sequencer state.
  `RKD_ASSERT_NOW(a_fill_from_fin, clk_i, rst_ni, ($rose(out_valid_o)), ($past(state_q) == S_FIN), "result appeared outside the final state")
  // An accepted item starts the modulus multiplication next.
  `RKD_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, (in_accept), (state_q == S_MODN), "accepted item did not start the sequence")

endmodule

>>> rtl/rkd_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Uses constants from rkd_pkg; instantiated by the key derivation top level.
module rkd_div #(
  parameter int unsigned W  = 2 * rkd_pkg::RKD_PRIME_BITS,
  parameter int unsigned DW = rkd_pkg::RKD_EXP_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [W-1:0]  divisor_i,
  output logic          done_o,
  output logic [W-1:0]  quotient_o,
  output logic [W-1:0]  remainder_o
);
  import rkd_pkg::*;

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W:0]    shifted;
  logic          ge;

  // The partial remainder stays below the divisor, so one more bit fits in W+1.
  assign shifted = {rem_q, quo_q[DW-1]};
  assign ge      = (shifted >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? W'(shifted - {1'b0, dvs_q}) : W'(shifted);
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = W'(quo_q);
  assign remainder_o = rem_q;

endmodule

>>> rtl/rkd_mulmod.sv
// Serial modular multiplier: one multiplier bit per cycle, reduced modulo m.
// Uses constants from rkd_pkg; instantiated by the key derivation top level.
module rkd_mulmod #(
  parameter int unsigned W = 2 * rkd_pkg::RKD_PRIME_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] m_i,
  output logic         done_o,
  output logic [W-1:0] product_o
);
  import rkd_pkg::*;

  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [W-1:0] acc_q, acc_d;
  logic [W-1:0] aa_q, aa_d;
  logic [W-1:0] bb_q, bb_d;
  logic [W-1:0] m_q, m_d;
  logic [W-1:0] gap_acc, gap_dbl;

  // Addition modulo m of two values below m, without a carry out of W bits.
  assign gap_acc = m_q - aa_q;
  assign gap_dbl = m_q - aa_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    aa_d   = aa_q;
    bb_d   = bb_q;
    m_d    = m_q;
    if (start_i) begin
      busy_d = 1'b1;
      acc_d  = '0;
      aa_d   = a_i;
      bb_d   = b_i;
      m_d    = m_i;
    end else if (busy_q) begin
      if (bb_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        if (bb_q[0]) begin
          acc_d = (acc_q >= gap_acc) ? (acc_q - gap_acc) : (acc_q + aa_q);
        end
        aa_d = (aa_q >= gap_dbl) ? (aa_q - gap_dbl) : (aa_q + aa_q);
        bb_d = bb_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    aa_q  <= aa_d;
    bb_q  <= bb_d;
    m_q   <= m_d;
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for rsa_key_pair_derivation: modulus and private exponent.
// Depends on rkd_pkg and the RTL of the block; expected keys come from an inverse
// computed here by the extended Euclidean algorithm on 64-bit integers.
module testbench;
  import rkd_pkg::*;

  // Generous bound on the whole run.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // The long receiver hold-off, in cycles.
  localparam int unsigned HOLD_CYCLES = 4000;
  // Quiet cycles after the last result, to catch a stray extra result.
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned MAX_REPORTS = 10;

  // One result item as the block reports it.
  typedef struct packed {
    logic [RKD_OUT_BITS-1:0] modulus;
    logic [RKD_OUT_BITS-1:0] priv_exp;
    logic                    found;
  } key_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [RKD_PRIME_BITS-1:0] prime_p = '0;
  logic [RKD_PRIME_BITS-1:0] prime_q = '0;
  logic [RKD_EXP_BITS-1:0]   pub_exp = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [RKD_OUT_BITS-1:0]   modulus;
  logic [RKD_OUT_BITS-1:0]   priv_exp;
  logic                      inv_found;

  // Keys still owed by the block, oldest first.
  key_result_t expected_keys[$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  // Random idling on either side; both switch together between tests.
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int unsigned rx_gap_left = 0;
  // The long hold-off is requested by a test and counted by its own process.
  bit hold_request = 1'b0;
  bit rx_hold = 1'b0;

  rsa_key_pair_derivation uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .prime_p_i         (prime_p),
    .prime_q_i         (prime_q),
    .public_exponent_i (pub_exp),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .modulus_o         (modulus),
    .private_exponent_o(priv_exp),
    .inverse_found_o   (inv_found)
  );

  always #10 clk = ~clk;

  // Watchdog. A hang anywhere in the block ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Predicts one key. The modulus is the full product cut to 32 bits. The
  // private exponent is the inverse of e modulo phi = (p-1)(q-1), where a
  // factor of zero or one gives a zero term. No inverse exists when phi is
  // below two or when e shares a factor with phi; then found is low and the
  // exponent is zero. The Bezout coefficients stay within plus or minus phi,
  // so signed 64-bit arithmetic holds them without overflow.
  function automatic key_result_t derive_key(input logic [RKD_PRIME_BITS-1:0] p,
                                             input logic [RKD_PRIME_BITS-1:0] q,
                                             input logic [RKD_EXP_BITS-1:0] e);
    key_result_t res;
    logic [63:0] pm1, qm1, phi, rem_a, rem_b, rem_t, quo;
    longint coef_a, coef_b, coef_t;
    pm1 = (p != 0) ? 64'(p) - 64'd1 : 64'd0;
    qm1 = (q != 0) ? 64'(q) - 64'd1 : 64'd0;
    phi = pm1 * qm1;
    res.modulus = RKD_OUT_BITS'(64'(p) * 64'(q));
    res.priv_exp = '0;
    res.found = 1'b0;
    if (phi >= 64'd2) begin
      rem_a = phi;
      rem_b = 64'(e) % phi;
      coef_a = 0;
      coef_b = 1;
      while (rem_b != 0) begin
        quo = rem_a / rem_b;
        rem_t = rem_a - quo * rem_b;
        coef_t = coef_a - longint'(quo) * coef_b;
        rem_a = rem_b;
        rem_b = rem_t;
        coef_a = coef_b;
        coef_b = coef_t;
      end
      if (rem_a == 64'd1) begin
        coef_a = coef_a % longint'(phi);
        if (coef_a < 0) coef_a += longint'(phi);
        if (coef_a != 0) begin
          res.found = 1'b1;
          res.priv_exp = RKD_OUT_BITS'(coef_a);
        end
      end
    end
    return res;
  endfunction

  // Smallest prime at or above start, or the largest below it when the field
  // has no room left above.
  function automatic logic [RKD_PRIME_BITS-1:0] next_prime(input int unsigned start);
    int unsigned cand;
    int unsigned div;
    bit is_prime;
    cand = (start < 2) ? 2 : start;
    for (int step = 0; step < 2; step++) begin
      while (cand >= 2 && cand <= 65535) begin
        is_prime = 1'b1;
        for (div = 2; div * div <= cand; div++) begin
          if (cand % div == 0) begin
            is_prime = 1'b0;
            break;
          end
        end
        if (is_prime) return RKD_PRIME_BITS'(cand);
        if (step == 0) cand++;
        else cand--;
      end
      cand = 65535;
    end
    return RKD_PRIME_BITS'(2);
  endfunction

  // A prime of random bit length, so that short and long Euclid runs both occur.
  function automatic logic [RKD_PRIME_BITS-1:0] draw_prime();
    int unsigned bits;
    bits = $urandom_range(2, RKD_PRIME_BITS);
    return next_prime($urandom_range(1 << (bits - 1), (1 << bits) - 1));
  endfunction

  // Receiver. After each result it draws a stall of random length; the count
  // runs down whether or not a result is waiting, so stalls land on every phase
  // of the block's work. The long hold-off overrides it.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      rx_gap_left = rx_idle_on ? $urandom_range(0, 19) : 0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
    end
    out_stall <= rx_hold || (rx_gap_left > 0);
  end

  // Long hold-off. It changes on the falling edge so that the receiver sees a
  // settled value at every rising edge.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
        hold_request = 1'b0;
      end
    end
  end

  // Result checker: every accepted result is compared with the oldest key owed.
  always @(posedge clk) begin
    key_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_keys.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: modulus %h exponent %h found %b",
                   modulus, priv_exp, inv_found);
      end else begin
        want = expected_keys.pop_front();
        if (modulus !== want.modulus || priv_exp !== want.priv_exp ||
            inv_found !== want.found) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: modulus %h/%h exponent %h/%h found %b/%b (expected/actual)",
                     want.modulus, modulus, want.priv_exp, priv_exp,
                     want.found, inv_found);
        end
      end
    end
  end

  // Sends one item. Called at a rising edge; returns at the edge that accepts
  // it, with valid still high so that a following item can go out back to back.
  task automatic send_key_request(input logic [RKD_PRIME_BITS-1:0] p,
                                  input logic [RKD_PRIME_BITS-1:0] q,
                                  input logic [RKD_EXP_BITS-1:0] e);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    prime_p <= p;
    prime_q <= q;
    pub_exp <= e;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_keys.push_back(derive_key(p, q, e));
  endtask

  // Lowers valid and waits until every key owed has come back.
  task automatic settle_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_keys.size() != 0) @(posedge clk);
  endtask

  // Switches idling on both sides. The change happens on a falling edge so the
  // receiver never races with it; the task returns on a rising edge.
  task automatic set_idling(input bit on);
    @(negedge clk);
    tx_idle_on = on;
    rx_idle_on = on;
    @(posedge clk);
  endtask

  // Field extremes and every case where no inverse exists.
  task automatic test_directed_cases();
    set_idling(1'b1);
    send_key_request(16'd0, 16'd0, 32'd1);              // both factors zero
    send_key_request(16'd1, 16'd65535, 32'd3);          // factor of one
    send_key_request(16'd65535, 16'd1, 32'hFFFF_FFFF);
    send_key_request(16'd0, 16'd65535, 32'd65537);
    send_key_request(16'd2, 16'd2, 32'd1);              // totient of one
    send_key_request(16'd2, 16'd3, 32'd1);              // smallest totient, e = 1
    send_key_request(16'd2, 16'd3, 32'd2);              // e a multiple of phi
    send_key_request(16'd3, 16'd5, 32'd4);              // e shares a factor with phi
    send_key_request(16'd3, 16'd5, 32'd0);              // zero exponent
    send_key_request(16'd61, 16'd53, 32'd17);
    send_key_request(16'd61, 16'd53, 32'd3121);         // e = phi + 1
    send_key_request(16'd65521, 16'd65519, 32'd65537);  // largest primes
    send_key_request(16'd65535, 16'd65535, 32'hFFFF_FFFF);
    send_key_request(16'd65535, 16'd65535, 32'hFFFF_FFFE);
    send_key_request(16'd65521, 16'd65521, 32'hFFFF_FFFF);
    send_key_request(16'd32749, 16'd2, 32'h8000_0001);
    send_key_request(16'd65521, 16'd3, 32'hAAAA_AAAB);
    send_key_request(16'd40961, 16'd59051, 32'h5555_5555);
    send_key_request(16'd7, 16'd11, 32'd60);            // e = phi
    send_key_request(16'd7, 16'd11, 32'd59);
    settle_requests();
  endtask

  // Random keys. Most are real prime pairs with exponents that usually have an
  // inverse; the rest are arbitrary factors or exponents built to fail.
  task automatic test_random_keys(input int unsigned count);
    logic [RKD_PRIME_BITS-1:0] p, q;
    logic [RKD_EXP_BITS-1:0] e;
    logic [63:0] phi;
    int unsigned kind;
    set_idling(1'b1);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        p = RKD_PRIME_BITS'($urandom);
        q = RKD_PRIME_BITS'($urandom_range(0, 65535));
      end else begin
        p = draw_prime();
        q = draw_prime();
      end
      phi = ((p != 0) ? 64'(p) - 1 : 64'd0) * ((q != 0) ? 64'(q) - 1 : 64'd0);
      kind = $urandom_range(0, 9);
      case (kind)
        6: e = 32'd65537;
        7: e = RKD_EXP_BITS'(phi * $urandom_range(0, 3) + $urandom_range(0, 3));
        8: e = $urandom;
        9: e = RKD_EXP_BITS'(64'(p) * $urandom_range(1, 1000));
        default: e = $urandom | 32'd1;
      endcase
      send_key_request(p, q, e);
    end
    settle_requests();
  endtask

  // No idling on either side: items and results move at full rate.
  task automatic test_back_to_back(input int unsigned count);
    set_idling(1'b0);
    repeat (count) send_key_request(draw_prime(), draw_prime(), $urandom | 32'd1);
    settle_requests();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // items, so a finished result waits at the output and the input stalls.
  task automatic test_output_backpressure(input int unsigned count);
    set_idling(1'b0);
    hold_request = 1'b1;
    repeat (count) send_key_request(draw_prime(), draw_prime(), $urandom | 32'd1);
    settle_requests();
    while (hold_request) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_keys(55);
    test_back_to_back(10);
    test_output_backpressure(8);
    test_random_keys(10);

    // Every key is back; watch a while longer for anything extra.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_keys.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/rkd_pkg.sv
rtl/rkd_div.sv
rtl/rkd_mulmod.sv
rtl/rsa_key_pair_derivation.sv
tb/testbench.sv
